// File: sv/bfa_pkg.sv
// Shared constants and codes of the bitmap free-list allocator.
`default_nettype none

package bfa_pkg;

	// Fixed field widths of the request and response items.
	localparam int OP_W     = 2;
	localparam int INDEX_W  = 12;
	localparam int STATUS_W = 3;

	// Default geometry of the free map.
	localparam int DEF_NUM_ENTRIES = 4096;
	localparam int DEF_WORD_BITS   = 32;

	// Fixed-point shift of the reciprocal that splits an index into word and bit.
	localparam int DIV_SHIFT = 26;

	// Request operations.
	localparam logic [OP_W-1:0] OP_FIND    = 2'd0;
	localparam logic [OP_W-1:0] OP_ALLOC   = 2'd1;
	localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;

	// Response status codes.
	localparam logic [STATUS_W-1:0] STAT_OK    = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_USED  = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_FREE  = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_NONE  = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_RANGE = 3'd4;

endpackage

`default_nettype wire

// File: sv/bfa_req_if.sv
// Request channel: valid/ready handshake carrying operation and index.
`default_nettype none

interface bfa_req_if import bfa_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [OP_W-1:0]    operation;
	logic [INDEX_W-1:0] index;

	modport source (output valid, output operation, output index, input ready);
	modport sink (input valid, input operation, input index, output ready);
endinterface

`default_nettype wire

// File: sv/bfa_rsp_if.sv
// Response channel: valid/ready handshake carrying found index and status.
`default_nettype none

interface bfa_rsp_if import bfa_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [INDEX_W-1:0]  found_index;
	logic [STATUS_W-1:0] status;

	modport source (output valid, output found_index, output status, input ready);
	modport sink (input valid, input found_index, input status, output ready);
endinterface

`default_nettype wire

// File: sv/bfa_map_ram.sv
// Free map storage: one write port and one registered read port.
`default_nettype none

module bfa_map_ram #(
	parameter int DEPTH = 128,
	parameter int WIDTH = 32,
	parameter int AW    = 7
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data_q
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write when enabled and read every cycle; a read of the word being written returns the old data.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

endmodule

`default_nettype wire

// File: sv/bfa_first_free.sv
// Priority encoder that finds the lowest set bit of one map word.
`default_nettype none

module bfa_first_free #(
	parameter int WORD_BITS = 32,
	parameter int BW        = 5
) (
	input  wire logic [WORD_BITS-1:0] word,
	output logic                      hit,
	output logic      [BW-1:0]        pos
);

	// Walk from the top so that the lowest set bit wins.
	always_comb begin
		hit = 1'b0;
		pos = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (word[i]) begin
				hit = 1'b1;
				pos = BW'(i);
			end
		end
	end

endmodule

`default_nettype wire

// File: sv/bitmap_free_list_allocator.sv
// Top level of the first-fit bitmap free-list allocator.
`default_nettype none

// The allocator keeps one free bit per entry (1 = free) in a map memory of
// ceil(NUM_ENTRIES / WORD_BITS) words and serves one request at a time.
// After reset the block first runs a clearing pass that sets every map word
// to all ones, one word per cycle, during which no request is accepted. A
// find reads the map one word per cycle through the memory's single read
// port and checks each word with a priority encoder; it stops at the first
// word that holds a free entry. Allocate and release are a read-modify-write
// of one word after the index is split into word and bit. Requests with an
// unused operation code or an index at or beyond NUM_ENTRIES are answered
// without touching the map. A finished result sits in an output register,
// and the next request is accepted while it waits to be taken.
module bitmap_free_list_allocator import bfa_pkg::*; #(
	parameter int NUM_ENTRIES = DEF_NUM_ENTRIES,
	parameter int WORD_BITS   = DEF_WORD_BITS
) (
	input wire logic  clk,
	input wire logic  arst_n,
	bfa_req_if.sink   req,
	bfa_rsp_if.source rsp
);

	localparam int MAP_WORDS = (NUM_ENTRIES + WORD_BITS - 1) / WORD_BITS;
	localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int BW        = $clog2(WORD_BITS);
	localparam int LAST_BITS = NUM_ENTRIES - (MAP_WORDS - 1) * WORD_BITS;
	localparam int RECIP     = ((2 ** DIV_SHIFT) + WORD_BITS - 1) / WORD_BITS;
	localparam int PW        = DIV_SHIFT + INDEX_W;

	localparam logic [AW-1:0]        LAST_ADDR = AW'(MAP_WORDS - 1);
	localparam logic [WORD_BITS-1:0] LAST_MASK =
		{WORD_BITS{1'b1}} >> (WORD_BITS - LAST_BITS);

	// Sequencer states.
	localparam logic [2:0] S_CLEAR  = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_FIND   = 3'd2;
	localparam logic [2:0] S_SPLIT  = 3'd3;
	localparam logic [2:0] S_READ   = 3'd4;
	localparam logic [2:0] S_UPDATE = 3'd5;
	localparam logic [2:0] S_RESP   = 3'd6;

	logic [2:0]           state_q;
	logic [OP_W-1:0]      op_q;
	logic [INDEX_W-1:0]   idx_q;
	logic [AW-1:0]        wa_q;
	logic [BW-1:0]        bit_q;
	logic [AW-1:0]        clr_addr_q;
	logic [AW-1:0]        scan_addr_q;
	logic [AW-1:0]        addr_s1;
	logic                 scan_vld_s1;
	logic [INDEX_W-1:0]   res_index_q;
	logic [STATUS_W-1:0]  res_status_q;
	logic                 rsp_vld_q;
	logic [INDEX_W-1:0]   rsp_index_q;
	logic [STATUS_W-1:0]  rsp_status_q;

	logic                 accept;
	logic                 out_free;
	logic                 in_range;
	logic [PW-1:0]        prod;
	logic [INDEX_W-1:0]   quot;
	logic [INDEX_W-1:0]   rem;
	logic                 wr_en;
	logic [AW-1:0]        wr_addr;
	logic [WORD_BITS-1:0] wr_data;
	logic [AW-1:0]        rd_addr;
	logic [WORD_BITS-1:0] rd_data;
	logic [WORD_BITS-1:0] scan_word;
	logic                 scan_hit;
	logic [BW-1:0]        scan_pos;
	logic                 scan_done;
	logic [INDEX_W-1:0]   scan_index;
	logic [WORD_BITS-1:0] bit_sel;
	logic                 upd_bit;
	logic                 upd_we;
	logic [WORD_BITS-1:0] upd_word;
	logic [STATUS_W-1:0]  upd_status;

	assign accept    = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign out_free  = !rsp_vld_q || rsp.ready;
	assign in_range  = (32'(req.index) < NUM_ENTRIES);

	// Word number by reciprocal multiplication; exact for every 12-bit index.
	assign prod = PW'(idx_q) * PW'(RECIP);
	assign quot = prod[DIV_SHIFT +: INDEX_W];
	assign rem  = idx_q - INDEX_W'(int'(wa_q) * WORD_BITS);

	// Map memory and its port multiplexing.
	assign rd_addr = (state_q == S_FIND) ? scan_addr_q : wa_q;
	assign wr_en   = (state_q == S_CLEAR) || ((state_q == S_UPDATE) && upd_we);
	assign wr_addr = (state_q == S_CLEAR) ? clr_addr_q : wa_q;
	assign wr_data = (state_q == S_CLEAR) ? {WORD_BITS{1'b1}} : upd_word;

	bfa_map_ram #(
		.DEPTH (MAP_WORDS),
		.WIDTH (WORD_BITS),
		.AW    (AW)
	) u_map_ram (
		.clk       (clk),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_addr   (rd_addr),
		.rd_data_q (rd_data)
	);

	// Bits of the last word past the end of the map never count as free.
	assign scan_word = (addr_s1 == LAST_ADDR) ? (rd_data & LAST_MASK) : rd_data;

	bfa_first_free #(
		.WORD_BITS (WORD_BITS),
		.BW        (BW)
	) u_first_free (
		.word (scan_word),
		.hit  (scan_hit),
		.pos  (scan_pos)
	);

	assign scan_done  = scan_vld_s1 && (scan_hit || (addr_s1 == LAST_ADDR));
	assign scan_index = INDEX_W'(int'(addr_s1) * WORD_BITS + int'(scan_pos));

	// Read-modify-write of the addressed word for allocate and release.
	assign bit_sel = WORD_BITS'(1) << bit_q;
	assign upd_bit = rd_data[bit_q];

	always_comb begin
		if (op_q == OP_ALLOC) begin
			upd_we     = upd_bit;
			upd_word   = rd_data & ~bit_sel;
			upd_status = upd_bit ? STAT_OK : STAT_USED;
		end else begin
			upd_we     = !upd_bit;
			upd_word   = rd_data | bit_sel;
			upd_status = upd_bit ? STAT_FREE : STAT_OK;
		end
	end

	// Sequencer and its control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_addr_q  <= '0;
			scan_addr_q <= '0;
			scan_vld_s1 <= 1'b0;
			rsp_vld_q   <= 1'b0;
		end else begin
			scan_vld_s1 <= (state_q == S_FIND) && !scan_done;
			// The result register fills as a result leaves S_RESP and empties when taken.
			if (state_q == S_RESP && out_free) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == LAST_ADDR) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					scan_addr_q <= '0;
					if (accept) begin
						if (req.operation == OP_FIND) begin
							state_q <= S_FIND;
						end else if (req.operation != OP_ALLOC &&
							req.operation != OP_RELEASE) begin
							state_q <= S_RESP;
						end else if (!in_range) begin
							state_q <= S_RESP;
						end else begin
							state_q <= S_SPLIT;
						end
					end
				end
				S_FIND: begin
					if (scan_addr_q != LAST_ADDR) begin
						scan_addr_q <= scan_addr_q + 1'b1;
					end
					if (scan_done) begin
						state_q <= S_RESP;
					end
				end
				S_SPLIT: begin
					state_q <= S_READ;
				end
				S_READ: begin
					state_q <= S_UPDATE;
				end
				S_UPDATE: begin
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Payload registers of the request in flight and its result.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q         <= req.operation;
			idx_q        <= req.index;
			res_index_q  <= req.index;
			res_status_q <= STAT_RANGE;
		end
		if (state_q == S_FIND) begin
			addr_s1 <= scan_addr_q;
		end
		if (scan_done) begin
			res_index_q  <= scan_hit ? scan_index : '0;
			res_status_q <= scan_hit ? STAT_OK : STAT_NONE;
		end
		if (state_q == S_SPLIT) begin
			wa_q <= AW'(quot);
		end
		if (state_q == S_READ) begin
			bit_q <= BW'(rem);
		end
		if (state_q == S_UPDATE) begin
			res_status_q <= upd_status;
		end
		if (state_q == S_RESP && out_free) begin
			rsp_index_q  <= res_index_q;
			rsp_status_q <= res_status_q;
		end
	end

	assign rsp.valid       = rsp_vld_q;
	assign rsp.found_index = rsp_index_q;
	assign rsp.status      = rsp_status_q;

	// An update changes exactly one bit of the word that it writes back.
	a_single_bit_update: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UPDATE && upd_we) |-> $countones(upd_word ^ rd_data) == 1)
		else $error("map update changed other than one bit");

	// The scan address never runs past the last map word.
	a_scan_in_map: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIND) |-> (scan_addr_q <= LAST_ADDR))
		else $error("find scan address beyond the map");

	// Only one item is in flight: an accepted item closes the request side.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !req.ready)
		else $error("request accepted while another is in flight");

	// The result register is only loaded when its previous item is gone.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_vld_q && !rsp.ready) |=> (rsp_vld_q && $stable(rsp_index_q)))
		else $error("pending result overwritten");

endmodule

`default_nettype wire
